### hdl/rpc_pkg.sv
// Shared types, constants and the sequencer microcode ROM for the
// restricted partition counter. No dependencies.
package rpc_pkg;

   localparam int TOTAL_W = 11;
   localparam int PART_W  = 8;
   localparam int COUNT_W = 64;

   localparam int DEF_MAX_TOTAL = 1024;
   localparam int DEF_MAX_PART  = 128;

   typedef struct packed {
      logic [TOTAL_W-1:0] total;
      logic [PART_W-1:0]  largest_part;
   } req_type;

   typedef struct packed {
      logic [COUNT_W-1:0] way_count;
      logic               saturated;
   } rsp_type;

   // Microcode
   localparam int STEP_W = 3;

   localparam logic [STEP_W-1:0] STEP_IDLE   = 3'd0;
   localparam logic [STEP_W-1:0] STEP_CLEAR  = 3'd1;
   localparam logic [STEP_W-1:0] STEP_PINIT  = 3'd2;
   localparam logic [STEP_W-1:0] STEP_READ   = 3'd3;
   localparam logic [STEP_W-1:0] STEP_ADDW   = 3'd4;
   localparam logic [STEP_W-1:0] STEP_NEXTP  = 3'd5;
   localparam logic [STEP_W-1:0] STEP_RDRES  = 3'd6;
   localparam logic [STEP_W-1:0] STEP_RESULT = 3'd7;

   typedef enum logic [2:0] {
      OP_LATCH,   // take a request
      OP_CLEAR,   // table[s] = (s == 0)
      OP_PINIT,   // p = 1, s = 1
      OP_READ,    // read table[s] and table[s-p]
      OP_ADDW,    // table[s] = sat(table[s] + table[s-p])
      OP_NEXTP,   // p = p + 1, s = p + 1
      OP_RDRES,   // read table[n]
      OP_RESULT   // load result register
   } op_type;

   typedef enum logic [2:0] {
      COND_NEVER,
      COND_NO_REQ,
      COND_S_NE_N,
      COND_P_NE_K,
      COND_K_ZERO,
      COND_OUT_BUSY
   } cond_type;

   typedef struct packed {
      op_type            op;
      cond_type          cond;
      logic [STEP_W-1:0] target;
   } ucode_type;

   function automatic ucode_type ucode_rom(input logic [STEP_W-1:0] step);
      ucode_type w;
      unique case (step)
         STEP_IDLE:   w = '{op: OP_LATCH,  cond: COND_NO_REQ,   target: STEP_IDLE};
         STEP_CLEAR:  w = '{op: OP_CLEAR,  cond: COND_S_NE_N,   target: STEP_CLEAR};
         STEP_PINIT:  w = '{op: OP_PINIT,  cond: COND_K_ZERO,   target: STEP_RDRES};
         STEP_READ:   w = '{op: OP_READ,   cond: COND_NEVER,    target: STEP_IDLE};
         STEP_ADDW:   w = '{op: OP_ADDW,   cond: COND_S_NE_N,   target: STEP_READ};
         STEP_NEXTP:  w = '{op: OP_NEXTP,  cond: COND_P_NE_K,   target: STEP_READ};
         STEP_RDRES:  w = '{op: OP_RDRES,  cond: COND_NEVER,    target: STEP_IDLE};
         // falls through by wrapping the step counter back to idle
         STEP_RESULT: w = '{op: OP_RESULT, cond: COND_OUT_BUSY, target: STEP_RESULT};
      endcase
      return w;
   endfunction

endpackage

### hdl/rpc_ram.sv
// Generic RAM: one write port, two read ports, registered read data.
// No package dependencies.
module rpc_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1025
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_a_addr,
   output logic [WIDTH-1:0]         rd_a_data,
   input  logic [$clog2(DEPTH)-1:0] rd_b_addr,
   output logic [WIDTH-1:0]         rd_b_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_a_data <= mem[rd_a_addr];
      rd_b_data <= mem[rd_b_addr];
   end

endmodule

### hdl/restricted_partition_counter_unit.sv
// Top level of the restricted partition counter: microcoded sequencer,
// counters and saturating adder. Uses rpc_pkg and rpc_ram.
//
// Counts the partitions of total into parts no larger than largest_part
// (clamped to MAX_TOTAL, MAX_PART and the total) by the coin-change sweep
// over a (MAX_TOTAL+1) x 64 scratch RAM. One item at a time; with n and k the
// clamped total and part limit, each part p = 1..k updates table[s] for
// s = p..n. Each table update has a read step, which reads table[s] and
// table[s-p] through the RAM's registered read ports, and then an add and
// write-back step. A new request is taken as soon as the sequencer is idle,
// even while the previous result waits.
module restricted_partition_counter_unit
   import rpc_pkg::*;
#(
   parameter int MAX_TOTAL = DEF_MAX_TOTAL,
   parameter int MAX_PART  = DEF_MAX_PART
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int AW = $clog2(MAX_TOTAL + 1);

   logic [STEP_W-1:0]  step_ff, step_in;
   logic [AW-1:0]      n_ff, n_in, k_ff, k_in, s_ff, s_in, p_ff, p_in;
   logic               ovf_ff, ovf_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   ucode_type          uc;
   logic               jump, out_free;
   logic [AW-1:0]      n_clamp, k_clamp;
   logic [31:0]        total_wide, k_wide;

   logic               wr_en;
   logic [AW-1:0]      wr_addr, rd_a_addr, rd_b_addr;
   logic [COUNT_W-1:0] wr_data, rd_a_data, rd_b_data;
   logic [COUNT_W:0]   sum;

   rpc_ram #(
      .WIDTH(COUNT_W),
      .DEPTH(MAX_TOTAL + 1)
   ) u_table (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_a_addr (rd_a_addr),
      .rd_a_data (rd_a_data),
      .rd_b_addr (rd_b_addr),
      .rd_b_data (rd_b_data)
   );

   // request clamping
   always_comb begin
      total_wide = 32'(req_data.total);
      if (total_wide > 32'(MAX_TOTAL)) begin
         n_clamp = AW'(MAX_TOTAL);
      end else begin
         n_clamp = AW'(req_data.total);
      end
      k_wide = 32'(req_data.largest_part);
      if (k_wide > 32'(MAX_PART)) begin
         k_wide = 32'(MAX_PART);
      end
      if (k_wide > 32'(n_clamp)) begin
         k_wide = 32'(n_clamp);
      end
      k_clamp = AW'(k_wide);
   end

   // sequencer
   always_comb begin
      uc       = ucode_rom(step_ff);
      out_free = !rsp_valid_ff || !rsp_stall;
      unique case (uc.cond)
         COND_NEVER:    jump = 1'b0;
         COND_NO_REQ:   jump = !req_valid;
         COND_S_NE_N:   jump = (s_ff != n_ff);
         COND_P_NE_K:   jump = (p_ff != k_ff);
         COND_K_ZERO:   jump = (k_ff == '0);
         COND_OUT_BUSY: jump = !out_free;
         default:       jump = 1'b0;
      endcase
      step_in = jump ? uc.target : step_ff + 1'b1;
   end

   assign sum       = {1'b0, rd_a_data} + {1'b0, rd_b_data};
   assign rd_b_addr = s_ff - p_ff;

   // datapath
   always_comb begin
      n_in         = n_ff;
      k_in         = k_ff;
      s_in         = s_ff;
      p_in         = p_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_addr      = s_ff;
      wr_data      = '0;
      rd_a_addr    = n_ff;
      unique case (uc.op)
         OP_LATCH: begin
            if (req_valid) begin
               n_in   = n_clamp;
               k_in   = k_clamp;
               s_in   = '0;
               ovf_in = 1'b0;
            end
         end
         OP_CLEAR: begin
            wr_en   = 1'b1;
            wr_data = (s_ff == '0) ? COUNT_W'(1) : '0;
            s_in    = s_ff + 1'b1;
         end
         OP_PINIT: begin
            p_in = AW'(1);
            s_in = AW'(1);
         end
         OP_READ: begin
            rd_a_addr = s_ff;
         end
         OP_ADDW: begin
            wr_en   = 1'b1;
            wr_data = sum[COUNT_W] ? '1 : sum[COUNT_W-1:0];
            ovf_in  = ovf_ff | sum[COUNT_W];
            s_in    = s_ff + 1'b1;
         end
         OP_NEXTP: begin
            p_in = p_ff + 1'b1;
            s_in = p_ff + 1'b1;
         end
         OP_RDRES: begin
         end
         OP_RESULT: begin
            if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.way_count = rd_a_data;
               rsp_data_in.saturated = ovf_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= STEP_IDLE;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff        <= n_in;
      k_ff        <= k_in;
      s_ff        <= s_in;
      p_ff        <= p_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = (uc.op != OP_LATCH);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### hdl/rpc_checker.sv
// Port-level checks for restricted_partition_counter_unit, attached by bind.
// Uses rpc_pkg.
module rpc_checker
   import rpc_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed or dropped");

   // one item at a time: the block goes busy right after a request transfer
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while previous item in progress");

   // a saturated count reads as all ones
   a_sat_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.saturated |-> (rsp_data.way_count == '1))
      else $error("saturated flag without maximum count");

   // a new result appears as the sequencer returns to idle
   a_result_idle: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !req_stall)
      else $error("result loaded while sequencer still busy");

endmodule

bind restricted_partition_counter_unit rpc_checker u_rpc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
